// ===== rtl/regular_grid_linear_interp_1d_defines.svh =====
// Assertion macros shared by the grid sampler RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef REGULAR_GRID_LINEAR_INTERP_1D_DEFINES_SVH
`define REGULAR_GRID_LINEAR_INTERP_1D_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define RGLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define RGLI_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgli_pkg.sv =====
// Shared constants, codes and types of the regular grid sampler.
// No dependencies; every other RTL file but the defines header imports it.
`default_nettype none

package rgli_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH   = 1024;
  localparam int unsigned DEFAULT_FRACTION_BITS = 16;

  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned FUZZ_W       = 31;
  localparam int unsigned NODE_COUNT_W = 11;
  localparam int unsigned INDEX_W      = 10;
  localparam int unsigned STATUS_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUZZ_MARGIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_CELL_MODE = 3'd6;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID_CELL  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0]      grid_origin;
    logic [VALUE_W-1:0]      inv_spacing;
    logic [VALUE_W-1:0]      bound_min;
    logic [VALUE_W-1:0]      bound_max;
    logic [FUZZ_W-1:0]       fuzz_margin;
    logic [NODE_COUNT_W-1:0] node_count;
    logic                    per_cell_mode;
  } cfg_t;

  // Control bits that travel with an item between pipeline modules.
  typedef struct packed {
    logic valid;
    logic query;
    logic outside;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rgli_in_if.sv =====
// Input channel of the grid sampler: valid/ready plus one write or query item.
// Depends on rgli_pkg for field widths.
`default_nettype none

interface rgli_in_if
  import rgli_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [INDEX_W-1:0]        sample_index;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      sample_invalid;
  logic signed [VALUE_W-1:0] query_position;
  logic                      first_of_batch;
  logic                      fuzz_requested;

  modport source (
    output valid, cmd, sample_index, sample_value, sample_invalid,
    output query_position, first_of_batch, fuzz_requested,
    input  ready
  );

  modport sink (
    input  valid, cmd, sample_index, sample_value, sample_invalid,
    input  query_position, first_of_batch, fuzz_requested,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rgli_out_if.sv =====
// Output channel of the grid sampler: valid/ready plus one result item.
// Depends on rgli_pkg for field widths.
`default_nettype none

interface rgli_out_if
  import rgli_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       result_status;
  logic [INDEX_W-1:0]        cell_used;

  modport source (
    output valid, result_value, result_status, cell_used,
    input  ready
  );

  modport sink (
    input  valid, result_value, result_status, cell_used,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rgli_locate.sv =====
// First two pipeline stages: bounds check, offset from origin, scaling by
// the inverse spacing, then cell index and fraction. Uses rgli_pkg, rgli_in_if.
`default_nettype none
`include "regular_grid_linear_interp_1d_defines.svh"

module rgli_locate
  import rgli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int unsigned FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  rgli_in_if.sink                in_ch_i,
  input  logic                   next_ready_i,
  output stage_ctl_t             ctl_o,
  output logic [AddrW-1:0]       ix_o,
  output logic [FRACTION_BITS:0] frac_o,
  output logic [INDEX_W-1:0]     wr_index_o,
  output logic [VALUE_W-1:0]     wr_value_o,
  output logic                   wr_invalid_o
);

  localparam int unsigned CntW = ($clog2(TABLE_DEPTH + 1) > NODE_COUNT_W) ?
                                 $clog2(TABLE_DEPTH + 1) : NODE_COUNT_W;
  localparam logic [CntW-1:0]          DepthCount = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0]          MinCount   = CntW'(2);
  localparam logic [FRACTION_BITS:0]   FracOne    = {1'b1, {FRACTION_BITS{1'b0}}};

  logic en1, en2;

  // Stage 1 registers.
  logic                  v1_q, query1_q, outside1_q, neg1_q;
  logic [VALUE_W-1:0]    mag1_q;
  logic [INDEX_W-1:0]    widx1_q;
  logic [VALUE_W-1:0]    wval1_q;
  logic                  winv1_q;

  // Stage 2 registers.
  logic                  v2_q, query2_q, outside2_q, neg2_q;
  logic [2*VALUE_W-1:0]  prod2_q;
  logic [INDEX_W-1:0]    widx2_q;
  logic [VALUE_W-1:0]    wval2_q;
  logic                  winv2_q;

  logic signed [VALUE_W+1:0] pos_x, lo, hi, bmin_x, bmax_x, fuzz_x;
  logic signed [VALUE_W:0]   pos_s, org_s, diff;
  logic                      outside;
  logic [2*VALUE_W-1:0]      prod;

  logic [CntW-1:0]    node_count, count, last, last_cell;
  logic [VALUE_W-1:0] ix_hi;
  logic               clamp;

  assign en2 = !v2_q || next_ready_i;
  assign en1 = !v1_q || en2;
  assign in_ch_i.ready = en1;

  // Bounds, widened on both sides by the fuzz margin when the first item of a batch asks for it.
  always_comb begin
    pos_x  = {{2{in_ch_i.query_position[VALUE_W-1]}}, in_ch_i.query_position};
    bmin_x = {{2{cfg_i.bound_min[VALUE_W-1]}}, cfg_i.bound_min};
    bmax_x = {{2{cfg_i.bound_max[VALUE_W-1]}}, cfg_i.bound_max};
    fuzz_x = (in_ch_i.first_of_batch && in_ch_i.fuzz_requested) ?
             {3'b000, cfg_i.fuzz_margin} : '0;
    lo = bmin_x - fuzz_x;
    hi = bmax_x + fuzz_x;
    outside = (pos_x < lo) || (pos_x > hi);
    pos_s = {in_ch_i.query_position[VALUE_W-1], in_ch_i.query_position};
    org_s = {cfg_i.grid_origin[VALUE_W-1], cfg_i.grid_origin};
    diff  = pos_s - org_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_ch_i.valid;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      query1_q   <= (in_ch_i.cmd == CMD_QUERY);
      outside1_q <= outside;
      neg1_q     <= diff[VALUE_W];
      mag1_q     <= diff[VALUE_W-1:0];
      widx1_q    <= in_ch_i.sample_index;
      wval1_q    <= in_ch_i.sample_value;
      winv1_q    <= in_ch_i.sample_invalid;
    end
  end

  // Offset times inverse spacing gives a Q32.32 grid coordinate.
  assign prod = mag1_q * cfg_i.inv_spacing;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      query2_q   <= query1_q;
      outside2_q <= outside1_q;
      neg2_q     <= neg1_q;
      prod2_q    <= prod;
      widx2_q    <= widx1_q;
      wval2_q    <= wval1_q;
      winv2_q    <= winv1_q;
    end
  end

  // Cell index and fraction. Past the last node the last cell is used with
  // a full fraction; before the origin cell zero with a zero fraction.
  always_comb begin
    node_count = CntW'(cfg_i.node_count);
    if (node_count < MinCount) begin
      count = MinCount;
    end else if (node_count > DepthCount) begin
      count = DepthCount;
    end else begin
      count = node_count;
    end
    last      = count - CntW'(1);
    last_cell = count - CntW'(2);
    ix_hi     = prod2_q[2*VALUE_W-1:VALUE_W];
    clamp     = ix_hi >= VALUE_W'(last);
    if (neg2_q) begin
      ix_o   = '0;
      frac_o = '0;
    end else if (clamp) begin
      ix_o   = last_cell[AddrW-1:0];
      frac_o = FracOne;
    end else begin
      ix_o   = ix_hi[AddrW-1:0];
      frac_o = {1'b0, prod2_q[VALUE_W-1 -: FRACTION_BITS]};
    end
  end

  assign ctl_o        = '{valid: v2_q, query: query2_q, outside: outside2_q};
  assign wr_index_o   = widx2_q;
  assign wr_value_o   = wval2_q;
  assign wr_invalid_o = winv2_q;

  `RGLI_ASSERT(a_cell_pair_in_table,
    (ctl_o.valid && ctl_o.query) |-> (VALUE_W'(ix_o) + VALUE_W'(2) <= VALUE_W'(TABLE_DEPTH)),
    "cell index leaves no room for its upper node")
  `RGLI_ASSERT(a_frac_at_most_one,
    frac_o[FRACTION_BITS] |-> (frac_o[FRACTION_BITS-1:0] == '0),
    "fraction exceeds one")
  `RGLI_ASSERT_NEXT(a_transfer_lands,
    in_ch_i.valid && in_ch_i.ready, v1_q,
    "accepted item did not enter the first stage")

endmodule

`default_nettype wire

// ===== rtl/rgli_table.sv =====
// Sample table stage: one write port and two registered read ports for the
// two nodes of a cell, stored with the invalid-cell mark. Uses rgli_pkg.
`default_nettype none

module rgli_table
  import rgli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int unsigned FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_ctl_t             ctl_i,
  input  logic [AddrW-1:0]       ix_i,
  input  logic [FRACTION_BITS:0] frac_i,
  input  logic [INDEX_W-1:0]     wr_index_i,
  input  logic [VALUE_W-1:0]     wr_value_i,
  input  logic                   wr_invalid_i,
  output logic                   ready_o,
  input  logic                   next_ready_i,
  output stage_ctl_t             ctl_o,
  output logic [VALUE_W-1:0]     v0_o,
  output logic [VALUE_W-1:0]     v1_o,
  output logic                   mark_o,
  output logic [AddrW-1:0]       ix_o,
  output logic [FRACTION_BITS:0] frac_o
);

  localparam int unsigned IdxW = (AddrW + 1 > INDEX_W) ? AddrW + 1 : INDEX_W;

  logic [VALUE_W:0] mem_q [TABLE_DEPTH];
  logic [VALUE_W:0] rd0_q, rd1_q;

  logic                   v3_q, outside3_q;
  logic [AddrW-1:0]       ix3_q;
  logic [FRACTION_BITS:0] frac3_q;

  logic             en3, wr_en;
  logic [IdxW-1:0]  widx_x;
  logic [AddrW-1:0] waddr, ix_next;

  assign en3     = !v3_q || next_ready_i;
  assign ready_o = en3;

  // Writes land when their item leaves the stage in front, so a later query
  // always reads after every earlier write.
  assign widx_x  = IdxW'(wr_index_i);
  assign waddr   = widx_x[AddrW-1:0];
  assign wr_en   = en3 && ctl_i.valid && !ctl_i.query && (widx_x < IdxW'(TABLE_DEPTH));
  assign ix_next = ix_i + AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= {wr_invalid_i, wr_value_i};
    if (en3) begin
      rd0_q <= mem_q[ix_i];
      rd1_q <= mem_q[ix_next];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= ctl_i.valid && ctl_i.query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      outside3_q <= ctl_i.outside;
      ix3_q      <= ix_i;
      frac3_q    <= frac_i;
    end
  end

  assign ctl_o  = '{valid: v3_q, query: 1'b1, outside: outside3_q};
  assign v0_o   = rd0_q[VALUE_W-1:0];
  assign v1_o   = rd1_q[VALUE_W-1:0];
  assign mark_o = rd0_q[VALUE_W];
  assign ix_o   = ix3_q;
  assign frac_o = frac3_q;

endmodule

`default_nettype wire

// ===== rtl/rgli_blend.sv =====
// Last three stages: node difference, fraction multiply, rounding with
// saturation and the output register. Uses rgli_pkg and rgli_out_if.
`default_nettype none
`include "regular_grid_linear_interp_1d_defines.svh"

module rgli_blend
  import rgli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int unsigned FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   per_cell_mode_i,
  input  stage_ctl_t             ctl_i,
  input  logic [VALUE_W-1:0]     v0_i,
  input  logic [VALUE_W-1:0]     v1_i,
  input  logic                   mark_i,
  input  logic [AddrW-1:0]       ix_i,
  input  logic [FRACTION_BITS:0] frac_i,
  output logic                   ready_o,
  rgli_out_if.source             out_ch_o
);

  localparam int unsigned CellExtW = (AddrW > INDEX_W) ? AddrW : INDEX_W;
  localparam int unsigned ProdW    = VALUE_W + 1 + FRACTION_BITS + 2;
  localparam int unsigned AccW     = ProdW + 1;
  localparam logic signed [AccW-1:0] Half = AccW'(1) << (FRACTION_BITS - 1);

  logic en4, en5, en6;

  // Stage 4 registers.
  logic                      v4_q;
  logic [STATUS_W-1:0]       status4_q;
  logic [INDEX_W-1:0]        cell4_q;
  logic signed [VALUE_W-1:0] v0_4_q;
  logic signed [VALUE_W:0]   delta4_q;
  logic [FRACTION_BITS:0]    frac4_q;

  // Stage 5 registers.
  logic                      v5_q;
  logic [STATUS_W-1:0]       status5_q;
  logic [INDEX_W-1:0]        cell5_q;
  logic signed [VALUE_W-1:0] v0_5_q;
  logic signed [ProdW-1:0]   prod5_q;

  // Output register.
  logic                      v6_q;
  logic [STATUS_W-1:0]       status6_q;
  logic [INDEX_W-1:0]        cell6_q;
  logic [VALUE_W-1:0]        value6_q;

  logic [STATUS_W-1:0]         status;
  logic [CellExtW-1:0]         ix_ext;
  logic [INDEX_W-1:0]          cell_sel;
  logic signed [VALUE_W:0]     v0_s, v1_s, delta;
  logic signed [FRACTION_BITS+1:0] frac_s;
  logic signed [ProdW-1:0]     prod;
  logic signed [AccW-1:0]      base, acc, scaled;
  logic                        fits;
  logic [VALUE_W-1:0]          blend_val, value;

  assign en6     = !v6_q || out_ch_o.ready;
  assign en5     = !v5_q || en6;
  assign en4     = !v4_q || en5;
  assign ready_o = en4;

  always_comb begin
    if (ctl_i.outside) begin
      status = STATUS_OUT_OF_BOUNDS;
    end else if (mark_i) begin
      status = STATUS_INVALID_CELL;
    end else begin
      status = STATUS_OK;
    end
    ix_ext   = CellExtW'(ix_i);
    cell_sel = ctl_i.outside ? '0 : ix_ext[INDEX_W-1:0];
    v0_s     = {v0_i[VALUE_W-1], v0_i};
    v1_s     = {v1_i[VALUE_W-1], v1_i};
    delta    = v1_s - v0_s;
  end

  // v0*(1-f) + v1*f is formed as v0*1 + (v1-v0)*f with a single multiply.
  assign frac_s = {1'b0, frac4_q};
  assign prod   = delta4_q * frac_s;

  // Add half an output LSB and floor: round to nearest, halves upward.
  always_comb begin
    base   = AccW'(v0_5_q) <<< FRACTION_BITS;
    acc    = base + AccW'(prod5_q) + Half;
    scaled = acc >>> FRACTION_BITS;
    fits   = (scaled[AccW-1:VALUE_W-1] == '0) || (scaled[AccW-1:VALUE_W-1] == '1);
    if (fits) begin
      blend_val = scaled[VALUE_W-1:0];
    end else if (scaled[AccW-1]) begin
      blend_val = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      blend_val = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    if (status5_q != STATUS_OK) begin
      value = '0;
    end else if (per_cell_mode_i) begin
      value = v0_5_q;
    end else begin
      value = blend_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= ctl_i.valid && ctl_i.query;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      status4_q <= status;
      cell4_q   <= cell_sel;
      v0_4_q    <= v0_i;
      delta4_q  <= delta;
      frac4_q   <= frac_i;
    end
    if (en5) begin
      status5_q <= status4_q;
      cell5_q   <= cell4_q;
      v0_5_q    <= v0_4_q;
      prod5_q   <= prod;
    end
    if (en6) begin
      status6_q <= status5_q;
      cell6_q   <= cell5_q;
      value6_q  <= value;
    end
  end

  assign out_ch_o.valid         = v6_q;
  assign out_ch_o.result_value  = value6_q;
  assign out_ch_o.result_status = status6_q;
  assign out_ch_o.cell_used     = cell6_q;

  `RGLI_ASSERT(a_reject_has_zero_value,
    (out_ch_o.valid && (out_ch_o.result_status != STATUS_OK)) |-> (out_ch_o.result_value == '0),
    "rejected query carries a nonzero value")
  `RGLI_ASSERT(a_outside_has_cell_zero,
    (out_ch_o.valid && (out_ch_o.result_status == STATUS_OUT_OF_BOUNDS)) |->
      (out_ch_o.cell_used == '0),
    "out-of-bounds query reports a cell")
  `RGLI_ASSERT_NEXT(a_result_reaches_output,
    v5_q && en6, v6_q,
    "result lost between the multiply stage and the output register")

endmodule

`default_nettype wire

// ===== rtl/regular_grid_linear_interp_1d.sv =====
// Top level of the regular 1-D grid sampler: configuration registers and
// the pipeline. Uses rgli_pkg, rgli_in_if, rgli_out_if and the rgli_* stages.
//
// Items enter at one per cycle while the pipe is not stalled. A write
// stores one table sample with its invalid-cell mark; a query returns one
// result. A stall holds a full stage only while every stage ahead of it
// is full too. Six register stages carry each query: bounds check
// and offset, the 32x32 product that scales the offset by the inverse
// spacing, the table read (one write and two read ports, nodes at the cell
// index and the one after it), the node difference, the fraction multiply,
// and rounding into the output register. Writes take effect in item order,
// so a query sees every write accepted before it. The table is not cleared
// by reset: read only entries that have been written. Write configuration
// only while no item is in flight.
`default_nettype none

module regular_grid_linear_interp_1d
  import rgli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int unsigned FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rgli_in_if.sink               in_ch_i,
  rgli_out_if.source            out_ch_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  cfg_t cfg_q;

  stage_ctl_t             loc_ctl, tab_ctl;
  logic [AddrW-1:0]       loc_ix, tab_ix;
  logic [FRACTION_BITS:0] loc_frac, tab_frac;
  logic [INDEX_W-1:0]     wr_index;
  logic [VALUE_W-1:0]     wr_value, tab_v0, tab_v1;
  logic                   wr_invalid, tab_mark;
  logic                   tab_ready, blend_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_origin   <= '0;
      cfg_q.inv_spacing   <= VALUE_W'(65536);
      cfg_q.bound_min     <= '0;
      cfg_q.bound_max     <= VALUE_W'(65536);
      cfg_q.fuzz_margin   <= '0;
      cfg_q.node_count    <= NODE_COUNT_W'(2);
      cfg_q.per_cell_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_ORIGIN:   cfg_q.grid_origin   <= cfg_data_i;
        CFG_INV_SPACING:   cfg_q.inv_spacing   <= cfg_data_i;
        CFG_BOUND_MIN:     cfg_q.bound_min     <= cfg_data_i;
        CFG_BOUND_MAX:     cfg_q.bound_max     <= cfg_data_i;
        CFG_FUZZ_MARGIN:   cfg_q.fuzz_margin   <= cfg_data_i[FUZZ_W-1:0];
        CFG_NODE_COUNT:    cfg_q.node_count    <= cfg_data_i[NODE_COUNT_W-1:0];
        CFG_PER_CELL_MODE: cfg_q.per_cell_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rgli_locate #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_ch_i     (in_ch_i),
    .next_ready_i(tab_ready),
    .ctl_o       (loc_ctl),
    .ix_o        (loc_ix),
    .frac_o      (loc_frac),
    .wr_index_o  (wr_index),
    .wr_value_o  (wr_value),
    .wr_invalid_o(wr_invalid)
  );

  rgli_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (loc_ctl),
    .ix_i        (loc_ix),
    .frac_i      (loc_frac),
    .wr_index_i  (wr_index),
    .wr_value_i  (wr_value),
    .wr_invalid_i(wr_invalid),
    .ready_o     (tab_ready),
    .next_ready_i(blend_ready),
    .ctl_o       (tab_ctl),
    .v0_o        (tab_v0),
    .v1_o        (tab_v1),
    .mark_o      (tab_mark),
    .ix_o        (tab_ix),
    .frac_o      (tab_frac)
  );

  rgli_blend #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .per_cell_mode_i(cfg_q.per_cell_mode),
    .ctl_i          (tab_ctl),
    .v0_i           (tab_v0),
    .v1_i           (tab_v1),
    .mark_i         (tab_mark),
    .ix_i           (tab_ix),
    .frac_i         (tab_frac),
    .ready_o        (blend_ready),
    .out_ch_o       (out_ch_o)
  );

endmodule

`default_nettype wire
